/* rtl/gemm_pkg.sv */
package gemm_pkg;

	localparam int TILE_ROWS_DEF = 8;
	localparam int TILE_COLS_DEF = 8;
	localparam int MAX_DEPTH_DEF = 256;
	localparam int APB_AW = 6;

	localparam logic [1:0] ACT_WR_A    = 2'd0;
	localparam logic [1:0] ACT_WR_B    = 2'd1;
	localparam logic [1:0] ACT_WR_C    = 2'd2;
	localparam logic [1:0] ACT_COMPUTE = 2'd3;

	localparam logic [2:0] REG_M_ROWS  = 3'd0;
	localparam logic [2:0] REG_N_COLS  = 3'd1;
	localparam logic [2:0] REG_K_DEPTH = 3'd2;
	localparam logic [2:0] REG_ALPHA   = 3'd3;
	localparam logic [2:0] REG_BETA    = 3'd4;

	localparam logic [63:0] FP_ONE      = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] FP_QNAN     = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] FP_INF      = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] FP_NEG_ZERO = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  row_index;
		logic [7:0]  col_index;
		logic [63:0] elem_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic [63:0] out_value;
		logic        last_flag;
	} rsp_t;

endpackage

/* rtl/gemm_ram.sv */
module gemm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/gemm_fma.sv */
module gemm_fma (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	input  logic [63:0] op_c,
	output logic        done,
	output logic [63:0] res
);

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_MUL  = 4'd1;
	localparam logic [3:0] F_LZ0  = 4'd2;
	localparam logic [3:0] F_LZ1  = 4'd3;
	localparam logic [3:0] F_CMP  = 4'd4;
	localparam logic [3:0] F_ALN  = 4'd5;
	localparam logic [3:0] F_ADD  = 4'd6;
	localparam logic [3:0] F_SHR  = 4'd7;
	localparam logic [3:0] F_RND  = 4'd8;

	localparam logic [1:0] PH_P = 2'd0;
	localparam logic [1:0] PH_C = 2'd1;
	localparam logic [1:0] PH_R = 2'd2;

	function automatic logic [3:0] lzc16(input logic [15:0] x);
		logic [3:0] pos;
		pos = '0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) begin
				pos = 4'(i);
			end
		end
		return ~pos;
	endfunction

	function automatic logic [127:0] shrj(input logic [127:0] x, input logic [13:0] n);
		logic [127:0] r;
		logic [127:0] mask;
		if (n >= 14'd128) begin
			r = '0;
			r[0] = |x;
		end else begin
			r = x >> n[6:0];
			mask = ~({128{1'b1}} << n[6:0]);
			r[0] = r[0] | (|(x & mask));
		end
		return r;
	endfunction

	logic [3:0]  state_q;
	logic [1:0]  ph_q;
	logic [2:0]  mcnt_q;
	logic        done_q;
	logic [63:0] res_q;

	logic [52:0]        ma_q, mb_q;
	logic [53:0]        pp_q;
	logic [5:0]         sh_q;
	logic [127:0]       w_q, pm_q, cm_q;
	logic signed [13:0] pe_q, ce_q, e_q, be_q;
	logic [13:0]        d_q;
	logic               sp_q, sc_q, sign_q, cz_q;
	logic [6:0]         p_q;
	logic [63:0]        t_q;
	logic [7:0]         lz_nz_q;
	logic [7:0][3:0]    lz_cnt_q;

	logic        s_sp, s_sc, an, bn, cn, ai, bi, ci, az, bz, cz;
	logic        spec;
	logic [63:0] spec_val;
	logic [10:0] ea_eff, eb_eff, ce_eff;
	logic signed [13:0] pe0, ce0;

	assign s_sp = op_a[63] ^ op_b[63];
	assign s_sc = op_c[63];
	assign an = op_a[62:0] > FP_INF_LO;
	assign bn = op_b[62:0] > FP_INF_LO;
	assign cn = op_c[62:0] > FP_INF_LO;
	assign ai = op_a[62:0] == FP_INF_LO;
	assign bi = op_b[62:0] == FP_INF_LO;
	assign ci = op_c[62:0] == FP_INF_LO;
	assign az = op_a[62:0] == '0;
	assign bz = op_b[62:0] == '0;
	assign cz = op_c[62:0] == '0;

	localparam logic [62:0] FP_INF_LO = gemm_pkg::FP_INF[62:0];

	always_comb begin
		spec = 1'b1;
		spec_val = gemm_pkg::FP_QNAN;
		if (an || bn || cn) begin
			spec_val = gemm_pkg::FP_QNAN;
		end else if (ai || bi) begin
			if (az || bz) begin
				spec_val = gemm_pkg::FP_QNAN;
			end else if (ci && (s_sc != s_sp)) begin
				spec_val = gemm_pkg::FP_QNAN;
			end else begin
				spec_val = {s_sp, FP_INF_LO};
			end
		end else if (ci) begin
			spec_val = op_c;
		end else if (az || bz) begin
			spec_val = cz ? {s_sp & s_sc, 63'b0} : op_c;
		end else begin
			spec = 1'b0;
		end
	end

	assign ea_eff = (op_a[62:52] == '0) ? 11'd1 : op_a[62:52];
	assign eb_eff = (op_b[62:52] == '0) ? 11'd1 : op_b[62:52];
	assign ce_eff = (op_c[62:52] == '0) ? 11'd1 : op_c[62:52];
	assign pe0 = $signed({3'b0, ea_eff}) + $signed({3'b0, eb_eff}) - 14'sd2150;
	assign ce0 = $signed({3'b0, ce_eff}) - 14'sd1075;

	// partial products of the 53x53 mantissa product
	logic [26:0] mx, my;
	logic [5:0]  msh;
	logic [53:0] mprod;

	always_comb begin
		unique case (mcnt_q[1:0])
			2'd0: begin
				mx = ma_q[26:0]; my = mb_q[26:0]; msh = 6'd0;
			end
			2'd1: begin
				mx = ma_q[26:0]; my = {1'b0, mb_q[52:27]}; msh = 6'd27;
			end
			2'd2: begin
				mx = {1'b0, ma_q[52:27]}; my = mb_q[26:0]; msh = 6'd27;
			end
			default: begin
				mx = {1'b0, ma_q[52:27]}; my = {1'b0, mb_q[52:27]}; msh = 6'd54;
			end
		endcase
	end

	assign mprod = 54'(mx) * 54'(my);

	logic [2:0]   lz_sel;
	logic [6:0]   lzc, nsh;
	logic [127:0] norm;

	always_comb begin
		lz_sel = '0;
		for (int c = 0; c < 8; c++) begin
			if (lz_nz_q[c]) begin
				lz_sel = 3'(c);
			end
		end
	end

	assign lzc  = {~lz_sel, lz_cnt_q[lz_sel]};
	assign nsh  = lzc - 7'd1;
	assign norm = w_q << nsh;

	logic               big_p, add_zero;
	logic signed [13:0] s_amt;
	logic [5:0]         ls_amt;
	logic [127:0]       t_left, t_right;
	logic [13:0]        rs_amt;

	assign big_p    = (pe_q > ce_q) || ((pe_q == ce_q) && (pm_q >= cm_q));
	assign add_zero = (sp_q != sc_q) && (pm_q == cm_q);

	assign s_amt   = $signed({7'b0, p_q}) - 14'sd52 + ((be_q < 14'sd1) ? (14'sd1 - be_q) : 14'sd0);
	assign ls_amt  = 6'(14'sd3 - s_amt);
	assign rs_amt  = 14'(s_amt - 14'sd3);
	assign t_left  = w_q << ls_amt;
	assign t_right = shrj(w_q, rs_amt);

	logic [60:0] mant, mant_r;
	logic        rinc;
	logic [63:0] field, bits, bits_c;

	assign mant   = t_q[63:3];
	assign rinc   = (t_q[2:0] > 3'd4) || ((t_q[2:0] == 3'd4) && mant[0]);
	assign mant_r = mant + 61'(rinc);
	assign field  = (be_q >= 14'sd1) ? {1'b0, 11'(be_q - 14'sd1), 52'b0} : 64'b0;
	assign bits   = field + {3'b0, mant_r};
	assign bits_c = (bits >= gemm_pkg::FP_INF) ? gemm_pkg::FP_INF : bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ph_q    <= PH_P;
			mcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						if (spec) begin
							done_q <= 1'b1;
						end else begin
							state_q <= F_MUL;
							mcnt_q  <= '0;
						end
					end
				end
				F_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) begin
						state_q <= F_LZ0;
						ph_q    <= PH_P;
					end
				end
				F_LZ0: state_q <= F_LZ1;
				F_LZ1: begin
					unique case (ph_q)
						PH_P: begin
							state_q <= F_LZ0;
							ph_q    <= cz_q ? PH_R : PH_C;
						end
						PH_C: state_q <= F_CMP;
						PH_R: state_q <= F_SHR;
						default: state_q <= F_IDLE;
					endcase
				end
				F_CMP: state_q <= F_ALN;
				F_ALN: state_q <= F_ADD;
				F_ADD: begin
					if (add_zero) begin
						state_q <= F_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= F_LZ0;
						ph_q    <= PH_R;
					end
				end
				F_SHR: begin
					if (be_q > 14'sd2046) begin
						state_q <= F_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= F_RND;
					end
				end
				F_RND: begin
					state_q <= F_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start) begin
					sp_q  <= s_sp;
					sc_q  <= s_sc;
					cz_q  <= cz;
					ma_q  <= {op_a[62:52] != '0, op_a[51:0]};
					mb_q  <= {op_b[62:52] != '0, op_b[51:0]};
					pe_q  <= pe0;
					cm_q  <= {75'b0, op_c[62:52] != '0, op_c[51:0]};
					ce_q  <= ce0;
					w_q   <= '0;
					res_q <= spec_val;
				end
			end
			F_MUL: begin
				if (mcnt_q != 3'd4) begin
					pp_q <= mprod;
					sh_q <= msh;
				end
				if (mcnt_q != 3'd0) begin
					w_q <= w_q + (128'(pp_q) << sh_q);
				end
			end
			F_LZ0: begin
				for (int c = 0; c < 8; c++) begin
					lz_nz_q[c]  <= |w_q[16*c +: 16];
					lz_cnt_q[c] <= lzc16(w_q[16*c +: 16]);
				end
			end
			F_LZ1: begin
				unique case (ph_q)
					PH_P: begin
						pm_q <= norm;
						pe_q <= pe_q - $signed({7'b0, nsh});
						if (cz_q) begin
							w_q    <= norm;
							e_q    <= pe_q - $signed({7'b0, nsh});
							sign_q <= sp_q;
						end else begin
							w_q <= cm_q;
						end
					end
					PH_C: begin
						cm_q <= norm;
						ce_q <= ce_q - $signed({7'b0, nsh});
					end
					PH_R: begin
						p_q  <= 7'd127 - lzc;
						be_q <= e_q + $signed({7'b0, 7'd127 - lzc}) + 14'sd1023;
					end
					default: begin
						p_q <= p_q;
					end
				endcase
			end
			F_CMP: begin
				if (big_p) begin
					e_q    <= pe_q;
					sign_q <= sp_q;
					d_q    <= 14'(pe_q - ce_q);
				end else begin
					pm_q   <= cm_q;
					cm_q   <= pm_q;
					e_q    <= ce_q;
					sign_q <= sc_q;
					d_q    <= 14'(ce_q - pe_q);
				end
			end
			F_ALN: cm_q <= shrj(cm_q, d_q);
			F_ADD: begin
				w_q   <= (sp_q == sc_q) ? (pm_q + cm_q) : (pm_q - cm_q);
				res_q <= '0;
			end
			F_SHR: begin
				t_q   <= (s_amt < 14'sd3) ? t_left[63:0] : t_right[63:0];
				res_q <= {sign_q, FP_INF_LO};
			end
			F_RND: res_q <= {sign_q, bits_c[62:0]};
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/gemm_tile_alpha_beta_fp64.sv */
// Write words may follow back to back.
// A compute word runs per C entry: a read of C, the beta scale unless beta is one,
// then per k two passes through the shared multiply-add unit (alpha times B, then A times
// that plus the sum), and the emit, which waits while a result word is still held.
// The multiply-add unit builds its 53x53 product from 4 partial products.
// Reset clears the sequencer and loads the registers; the stores are undefined until written.
module gemm_tile_alpha_beta_fp64 #(
	parameter int TILE_ROWS = gemm_pkg::TILE_ROWS_DEF,
	parameter int TILE_COLS = gemm_pkg::TILE_COLS_DEF,
	parameter int MAX_DEPTH = gemm_pkg::MAX_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  gemm_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output gemm_pkg::rsp_t              rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gemm_pkg::APB_AW-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	localparam int RIW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int CIW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int KIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int KDW = $clog2(MAX_DEPTH + 1);
	localparam int AB_DEPTH = TILE_ROWS * MAX_DEPTH;
	localparam int BB_DEPTH = MAX_DEPTH * TILE_COLS;
	localparam int C_DEPTH  = TILE_ROWS * TILE_COLS;
	localparam int AAW = (AB_DEPTH > 1) ? $clog2(AB_DEPTH) : 1;
	localparam int BAW = (BB_DEPTH > 1) ? $clog2(BB_DEPTH) : 1;
	localparam int CAW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CRD    = 4'd1;
	localparam logic [3:0] S_CDAT   = 4'd2;
	localparam logic [3:0] S_CBETA  = 4'd3;
	localparam logic [3:0] S_KRD    = 4'd4;
	localparam logic [3:0] S_KSTART = 4'd5;
	localparam logic [3:0] S_KALPHA = 4'd6;
	localparam logic [3:0] S_KFMA   = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;

	logic [3:0]  m_rows_q, n_cols_q;
	logic [8:0]  k_depth_q;
	logic [63:0] alpha_q, beta_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_rows_q  <= 4'd8;
			n_cols_q  <= 4'd8;
			k_depth_q <= 9'd256;
			alpha_q   <= gemm_pkg::FP_ONE;
			beta_q    <= gemm_pkg::FP_ONE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				gemm_pkg::REG_M_ROWS:  m_rows_q  <= pwdata[3:0];
				gemm_pkg::REG_N_COLS:  n_cols_q  <= pwdata[3:0];
				gemm_pkg::REG_K_DEPTH: k_depth_q <= pwdata[8:0];
				gemm_pkg::REG_ALPHA:   alpha_q   <= pwdata;
				gemm_pkg::REG_BETA:    beta_q    <= pwdata;
				default: begin
					alpha_q <= alpha_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			gemm_pkg::REG_M_ROWS:  prdata = {60'b0, m_rows_q};
			gemm_pkg::REG_N_COLS:  prdata = {60'b0, n_cols_q};
			gemm_pkg::REG_K_DEPTH: prdata = {55'b0, k_depth_q};
			gemm_pkg::REG_ALPHA:   prdata = alpha_q;
			gemm_pkg::REG_BETA:    prdata = beta_q;
			default:               prdata = '0;
		endcase
	end

	logic [3:0]     st_q;
	logic [RIW-1:0] i_q;
	logic [CIW-1:0] j_q;
	logic [KIW-1:0] k_q;
	logic [3:0]     mi_q, nj_q;
	logic [KDW-1:0] kd_q;
	logic           rsp_valid_q;
	gemm_pkg::rsp_t rsp_q;
	logic [63:0]    acc_q;

	logic [3:0]     m_sat, n_sat;
	logic [KDW-1:0] kd_sat;
	logic           acc_req, is_compute, beta_one, emit_fire, last_ent, j_wrap, k_last;

	assign m_sat  = (m_rows_q > 4'(TILE_ROWS)) ? 4'(TILE_ROWS) : m_rows_q;
	assign n_sat  = (n_cols_q > 4'(TILE_COLS)) ? 4'(TILE_COLS) : n_cols_q;
	assign kd_sat = (int'(k_depth_q) > MAX_DEPTH) ? KDW'(MAX_DEPTH) : KDW'(k_depth_q);

	assign req_ready  = (st_q == S_IDLE);
	assign acc_req    = req_valid & req_ready;
	assign is_compute = (req_data.action == gemm_pkg::ACT_COMPUTE);
	assign beta_one   = (beta_q == gemm_pkg::FP_ONE);
	assign emit_fire  = (st_q == S_EMIT) && (!rsp_valid_q || rsp_ready);
	assign j_wrap     = (4'(j_q) + 4'd1 == nj_q);
	assign last_ent   = (4'(i_q) + 4'd1 == mi_q) && j_wrap;
	assign k_last     = (KDW'(k_q) + KDW'(1) == kd_q);

	logic        fma_start, fma_done;
	logic [63:0] fma_a, fma_b, fma_c, fma_res;
	logic [63:0] a_rdata, b_rdata, c_rdata;

	always_comb begin
		fma_start = 1'b0;
		fma_a     = alpha_q;
		fma_b     = b_rdata;
		fma_c     = gemm_pkg::FP_NEG_ZERO;
		unique case (st_q)
			S_CDAT: begin
				fma_start = !beta_one;
				fma_a     = c_rdata;
				fma_b     = beta_q;
			end
			S_KSTART: begin
				fma_start = 1'b1;
			end
			S_KALPHA: begin
				fma_start = fma_done;
				fma_a     = a_rdata;
				fma_b     = fma_res;
				fma_c     = acc_q;
			end
			default: begin
				fma_start = 1'b0;
			end
		endcase
	end

	gemm_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fma_start),
		.op_a   (fma_a),
		.op_b   (fma_b),
		.op_c   (fma_c),
		.done   (fma_done),
		.res    (fma_res)
	);

	logic           wa_en, wb_en, wc_en, c_we;
	logic [AAW-1:0] a_waddr, a_raddr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [CAW-1:0] c_waddr, c_eaddr, c_addr;

	assign wa_en = acc_req && (req_data.action == gemm_pkg::ACT_WR_A)
		&& (int'(req_data.row_index) < TILE_ROWS) && (int'(req_data.col_index) < MAX_DEPTH);
	assign wb_en = acc_req && (req_data.action == gemm_pkg::ACT_WR_B)
		&& (int'(req_data.row_index) < MAX_DEPTH) && (int'(req_data.col_index) < TILE_COLS);
	assign wc_en = acc_req && (req_data.action == gemm_pkg::ACT_WR_C)
		&& (int'(req_data.row_index) < TILE_ROWS) && (int'(req_data.col_index) < TILE_COLS);

	assign a_waddr = AAW'(int'(req_data.row_index) * MAX_DEPTH + int'(req_data.col_index));
	assign b_waddr = BAW'(int'(req_data.row_index) * TILE_COLS + int'(req_data.col_index));
	assign c_waddr = CAW'(int'(req_data.row_index) * TILE_COLS + int'(req_data.col_index));
	assign a_raddr = AAW'(int'(i_q) * MAX_DEPTH + int'(k_q));
	assign b_raddr = BAW'(int'(k_q) * TILE_COLS + int'(j_q));
	assign c_eaddr = CAW'(int'(i_q) * TILE_COLS + int'(j_q));
	assign c_we    = wc_en || emit_fire;
	assign c_addr  = emit_fire ? c_eaddr : c_waddr;

	gemm_ram #(.WIDTH(64), .DEPTH(AB_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (wa_en),
		.waddr (a_waddr),
		.wdata (req_data.elem_value),
		.re    (st_q == S_KRD),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	gemm_ram #(.WIDTH(64), .DEPTH(BB_DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (wb_en),
		.waddr (b_waddr),
		.wdata (req_data.elem_value),
		.re    (st_q == S_KRD),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	gemm_ram #(.WIDTH(64), .DEPTH(C_DEPTH)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_addr),
		.wdata (emit_fire ? acc_q : req_data.elem_value),
		.re    (st_q == S_CRD),
		.raddr (c_eaddr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			mi_q        <= '0;
			nj_q        <= '0;
			kd_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (acc_req && is_compute) begin
						mi_q <= m_sat;
						nj_q <= n_sat;
						kd_q <= kd_sat;
						i_q  <= '0;
						j_q  <= '0;
						if (m_sat != '0 && n_sat != '0) begin
							st_q <= S_CRD;
						end
					end
				end
				S_CRD: st_q <= S_CDAT;
				S_CDAT: begin
					k_q <= '0;
					if (!beta_one) begin
						st_q <= S_CBETA;
					end else begin
						st_q <= (kd_q == '0) ? S_EMIT : S_KRD;
					end
				end
				S_CBETA: begin
					if (fma_done) begin
						st_q <= (kd_q == '0) ? S_EMIT : S_KRD;
					end
				end
				S_KRD:    st_q <= S_KSTART;
				S_KSTART: st_q <= S_KALPHA;
				S_KALPHA: begin
					if (fma_done) begin
						st_q <= S_KFMA;
					end
				end
				S_KFMA: begin
					if (fma_done) begin
						if (k_last) begin
							st_q <= S_EMIT;
						end else begin
							k_q  <= k_q + KIW'(1);
							st_q <= S_KRD;
						end
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (last_ent) begin
							st_q <= S_IDLE;
						end else begin
							st_q <= S_CRD;
							if (j_wrap) begin
								j_q <= '0;
								i_q <= i_q + RIW'(1);
							end else begin
								j_q <= j_q + CIW'(1);
							end
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_CDAT && beta_one) begin
			acc_q <= c_rdata;
		end else if ((st_q == S_CBETA || st_q == S_KFMA) && fma_done) begin
			acc_q <= fma_res;
		end
		if (emit_fire) begin
			rsp_q.out_row   <= 3'(i_q);
			rsp_q.out_col   <= 3'(j_q);
			rsp_q.out_value <= acc_q;
			rsp_q.last_flag <= last_ent;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* rtl/gemm_chk.sv */
module gemm_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input gemm_pkg::req_t req_data,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input gemm_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word dropped or changed while stalled");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last_flag |-> !req_ready)
		else $error("input taken in the middle of a result run");

	a_write_short: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.action != gemm_pkg::ACT_COMPUTE) |=> req_ready)
		else $error("element write held off the next word");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && (req_data.action == gemm_pkg::ACT_COMPUTE)))
		else $error("block went busy without a compute word");

endmodule

bind gemm_tile_alpha_beta_fp64 gemm_chk u_gemm_chk (.*);

/* sim/tb.sv */
module tb;
	import gemm_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req_data;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;

	gemm_tile_alpha_beta_fp64 dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [63:0] a_mem [8][256];
	logic [63:0] b_mem [256][8];
	logic [63:0] c_mem [8][8];
	bit          a_set [8][256];
	bit          b_set [256][8];
	bit          c_set [8][8];
	logic [3:0]  m_q;
	logic [3:0]  n_q;
	logic [8:0]  k_q;
	logic [63:0] alpha_q;
	logic [63:0] beta_q;

	rsp_t expected_entries [$];
	int   errors;
	int   words_sent;
	int   entries_seen;
	int   computes_sent;
	int   idle_cycles;
	int   stall_left;
	bit   quiet;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int msb128(logic [127:0] x);
		int p;
		p = -1;
		for (int i = 127; i >= 0; i--) begin
			if (x[i]) begin
				p = i;
				break;
			end
		end
		return p;
	endfunction

	function automatic logic [127:0] shr_sticky(logic [127:0] x, int n);
		logic [127:0] mask;
		if (n <= 0)
			return x;
		if (n >= 128)
			return {127'b0, |x};
		mask = (128'b1 << n) - 128'b1;
		return (x >> n) | {127'b0, |(x & mask)};
	endfunction

	function automatic bit is_nan(logic [63:0] x);
		return x[62:0] > FP_INF[62:0];
	endfunction

	function automatic logic [63:0] scale_mul(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		r = $realtobits($bitstoreal(x) * $bitstoreal(y));
		return is_nan(r) ? FP_QNAN : r;
	endfunction

	function automatic logic [63:0] fused_madd(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic         sp, sc, sign, ai, bi, az, bz;
		logic [127:0] pm, cm, rm, big, sm;
		logic [63:0]  t, mant, field, bits;
		int           ea, eb, pe, ce, e, p, be, s;
		if (is_nan(a) || is_nan(b) || is_nan(c))
			return FP_QNAN;
		sp = a[63] ^ b[63];
		sc = c[63];
		ai = a[62:0] == FP_INF[62:0];
		bi = b[62:0] == FP_INF[62:0];
		az = a[62:0] == 63'b0;
		bz = b[62:0] == 63'b0;
		if (ai || bi) begin
			if (az || bz)
				return FP_QNAN;
			if (c[62:0] == FP_INF[62:0] && sc != sp)
				return FP_QNAN;
			return {sp, FP_INF[62:0]};
		end
		if (c[62:0] == FP_INF[62:0])
			return c;
		if (az || bz) begin
			if (c[62:0] == 63'b0)
				return {sp & sc, 63'b0};
			return c;
		end
		ea = a[62:52];
		eb = b[62:52];
		pm = {75'b0, (ea != 0), a[51:0]} * {75'b0, (eb != 0), b[51:0]};
		if (ea == 0) ea = 1;
		if (eb == 0) eb = 1;
		pe = ea + eb - 2150;
		p = msb128(pm);
		pm = pm << (126 - p);
		pe -= 126 - p;
		if (c[62:0] == 63'b0) begin
			rm = pm;
			e = pe;
			sign = sp;
		end else begin
			ce = c[62:52];
			cm = {75'b0, (ce != 0), c[51:0]};
			if (ce == 0) ce = 1;
			ce -= 1075;
			p = msb128(cm);
			cm = cm << (126 - p);
			ce -= 126 - p;
			if (pe > ce || (pe == ce && pm >= cm)) begin
				big = pm;
				e = pe;
				sign = sp;
				sm = shr_sticky(cm, pe - ce);
			end else begin
				big = cm;
				e = ce;
				sign = sc;
				sm = shr_sticky(pm, ce - pe);
			end
			if (sp == sc)
				rm = big + sm;
			else begin
				rm = big - sm;
				if (rm == 128'b0)
					return 64'b0;
			end
		end
		p = msb128(rm);
		be = e + p + 1023;
		if (be > 2046)
			return {sign, FP_INF[62:0]};
		s = p - 52;
		if (be < 1)
			s += 1 - be;
		if (s < 3)
			t = rm[63:0] << (3 - s);
		else begin
			rm = shr_sticky(rm, s - 3);
			t = rm[63:0];
		end
		mant = t >> 3;
		if (t[2:0] > 3'd4 || (t[2:0] == 3'd4 && mant[0]))
			mant++;
		field = (be >= 1) ? (64'(be - 1) << 52) : 64'b0;
		bits = field + mant;
		if (bits >= FP_INF)
			bits = FP_INF;
		return {sign, bits[62:0]};
	endfunction

	task automatic predict_word(req_t w);
		int          m, n, kd;
		logic [63:0] acc;
		rsp_t        e;
		case (w.action)
			ACT_WR_A: begin
				if (w.row_index < 8) begin
					a_mem[w.row_index][w.col_index] = w.elem_value;
					a_set[w.row_index][w.col_index] = 1'b1;
				end
			end
			ACT_WR_B: begin
				if (w.col_index < 8) begin
					b_mem[w.row_index][w.col_index] = w.elem_value;
					b_set[w.row_index][w.col_index] = 1'b1;
				end
			end
			ACT_WR_C: begin
				if (w.row_index < 8 && w.col_index < 8) begin
					c_mem[w.row_index][w.col_index] = w.elem_value;
					c_set[w.row_index][w.col_index] = 1'b1;
				end
			end
			default: begin
				m = (m_q < 8) ? m_q : 8;
				n = (n_q < 8) ? n_q : 8;
				kd = (k_q < 256) ? k_q : 256;
				for (int i = 0; i < m; i++) begin
					for (int j = 0; j < n; j++) begin
						acc = c_mem[i][j];
						if (beta_q != FP_ONE)
							acc = scale_mul(acc, beta_q);
						for (int k = 0; k < kd; k++)
							acc = fused_madd(a_mem[i][k], scale_mul(alpha_q, b_mem[k][j]), acc);
						c_mem[i][j] = acc;
						e.out_row = i;
						e.out_col = j;
						e.out_value = acc;
						e.last_flag = (i + 1 == m && j + 1 == n);
						expected_entries.push_back(e);
					end
				end
			end
		endcase
	endtask

	function automatic logic [63:0] rand_fp();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0: v = {v[63], 63'b0};
			1: v = {v[63], FP_INF[62:0]};
			2: v = {v[63], 11'h7FF, v[51:1], 1'b1};
			3: v = {v[63], 11'h000, v[51:0]};
			4: v = {v[63], FP_ONE[62:0]};
			5: v = v;
			6: v = {v[63], 11'(2040 + $urandom_range(0, 6)), v[51:0]};
			7: v = {v[63], 11'($urandom_range(1, 8)), v[51:0]};
			default: v = {v[63], 11'(1013 + $urandom_range(0, 20)), v[51:0]};
		endcase
		return v;
	endfunction

	function automatic req_t mk(logic [1:0] act, int r, int c, logic [63:0] v);
		req_t w;
		w.action = act;
		w.row_index = r;
		w.col_index = c;
		w.elem_value = v;
		return w;
	endfunction

	task automatic send_word(req_t w);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= w;
		do @(posedge clk); while (!req_ready);
		predict_word(w);
		words_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		wait (expected_entries.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_M_ROWS:  m_q = val[3:0];
			REG_N_COLS:  n_q = val[3:0];
			REG_K_DEPTH: k_q = val[8:0];
			REG_ALPHA:   alpha_q = val;
			default:     beta_q = val;
		endcase
	endtask

	task automatic set_shape(int m, int n, int k, logic [63:0] alpha, logic [63:0] beta);
		reg_write(REG_M_ROWS, m);
		reg_write(REG_N_COLS, n);
		reg_write(REG_K_DEPTH, k);
		reg_write(REG_ALPHA, alpha);
		reg_write(REG_BETA, beta);
	endtask

	task automatic issue_compute();
		int m, n, kd;
		m = (m_q < 8) ? m_q : 8;
		n = (n_q < 8) ? n_q : 8;
		kd = (k_q < 256) ? k_q : 256;
		if (m > 0 && n > 0) begin
			for (int i = 0; i < m; i++)
				for (int k = 0; k < kd; k++)
					if (!a_set[i][k]) send_word(mk(ACT_WR_A, i, k, rand_fp()));
			for (int k = 0; k < kd; k++)
				for (int j = 0; j < n; j++)
					if (!b_set[k][j]) send_word(mk(ACT_WR_B, k, j, rand_fp()));
			for (int i = 0; i < m; i++)
				for (int j = 0; j < n; j++)
					if (!c_set[i][j]) send_word(mk(ACT_WR_C, i, j, rand_fp()));
		end
		send_word(mk(ACT_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255), rand_fp()));
		computes_sent++;
	endtask

	task automatic test_specials();
		set_shape(1, 1, 1, FP_ONE, FP_ONE);
		send_word(mk(ACT_WR_A, 0, 0, FP_INF));
		send_word(mk(ACT_WR_B, 0, 0, 64'b0));
		send_word(mk(ACT_WR_C, 0, 0, 64'h4000_0000_0000_0000));
		issue_compute();
		send_word(mk(ACT_WR_A, 0, 0, FP_INF));
		send_word(mk(ACT_WR_B, 0, 0, FP_ONE));
		send_word(mk(ACT_WR_C, 0, 0, {1'b1, FP_INF[62:0]}));
		issue_compute();
		send_word(mk(ACT_WR_A, 0, 0, FP_ONE));
		send_word(mk(ACT_WR_B, 0, 0, 64'h4000_0000_0000_0000));
		send_word(mk(ACT_WR_C, 0, 0, 64'hC000_0000_0000_0000));
		issue_compute();
		send_word(mk(ACT_WR_A, 0, 0, FP_NEG_ZERO));
		send_word(mk(ACT_WR_B, 0, 0, FP_ONE));
		send_word(mk(ACT_WR_C, 0, 0, FP_NEG_ZERO));
		issue_compute();
		send_word(mk(ACT_WR_A, 0, 0, 64'h0000_0000_0000_0003));
		send_word(mk(ACT_WR_B, 0, 0, 64'h3FE0_0000_0000_0001));
		send_word(mk(ACT_WR_C, 0, 0, 64'h0000_0000_0000_0001));
		issue_compute();
		send_word(mk(ACT_WR_A, 0, 0, 64'h7FEF_FFFF_FFFF_FFFF));
		send_word(mk(ACT_WR_B, 0, 0, 64'h4000_0000_0000_0000));
		send_word(mk(ACT_WR_A, 8, 0, FP_QNAN));
		send_word(mk(ACT_WR_B, 0, 8, FP_QNAN));
		send_word(mk(ACT_WR_C, 255, 255, FP_QNAN));
		issue_compute();
	endtask

	task automatic test_shapes();
		set_shape(0, 8, 1, FP_ONE, 64'h4000_0000_0000_0000);
		issue_compute();
		set_shape(8, 0, 1, FP_ONE, FP_ONE);
		issue_compute();
		set_shape(2, 3, 0, {$urandom, $urandom}, 64'hBFF8_0000_0000_0000);
		issue_compute();
		set_shape(15, 15, 1, 64'hC008_0000_0000_0000, FP_QNAN);
		issue_compute();
		set_shape(1, 1, 511, FP_ONE, 64'b0);
		issue_compute();
		set_shape(1, 2, 256, 64'h3FE0_0000_0000_0000, FP_ONE);
		issue_compute();
		drain();
		issue_compute();
	endtask

	task automatic test_random();
		int budget;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				quiet = 1'b1;
			set_shape(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
				$urandom_range(0, 8),
				($urandom_range(0, 2) == 0) ? FP_ONE : rand_fp(),
				($urandom_range(0, 2) == 0) ? FP_ONE : rand_fp());
			budget = 45;
			while (budget > 0) begin
				budget--;
				case ($urandom_range(0, 9))
					0, 1: issue_compute();
					2: send_word(mk($urandom_range(0, 2), $urandom_range(0, 255),
						$urandom_range(0, 255), {$urandom, $urandom}));
					3, 4: send_word(mk(ACT_WR_A, $urandom_range(0, 7), $urandom_range(0, 8),
						rand_fp()));
					5, 6: send_word(mk(ACT_WR_B, $urandom_range(0, 8), $urandom_range(0, 7),
						rand_fp()));
					default: send_word(mk(ACT_WR_C, $urandom_range(0, 7), $urandom_range(0, 7),
						rand_fp()));
				endcase
			end
			issue_compute();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 12);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			entries_seen++;
			if (expected_entries.size() == 0) begin
				$error("unexpected entry row %0d col %0d", rsp_data.out_row, rsp_data.out_col);
				errors++;
			end else begin
				e = expected_entries.pop_front();
				if (rsp_data.out_row !== e.out_row) begin
					$error("out_row expected %0d actual %0d", e.out_row, rsp_data.out_row);
					errors++;
				end
				if (rsp_data.out_col !== e.out_col) begin
					$error("out_col expected %0d actual %0d", e.out_col, rsp_data.out_col);
					errors++;
				end
				if (rsp_data.out_value !== e.out_value) begin
					$error("out_value expected %h actual %h", e.out_value, rsp_data.out_value);
					errors++;
				end
				if (rsp_data.last_flag !== e.last_flag) begin
					$error("last_flag expected %0d actual %0d", e.last_flag, rsp_data.last_flag);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** gemm_tile_alpha_beta_fp64: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		words_sent = 0;
		entries_seen = 0;
		computes_sent = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		m_q = 4'd8;
		n_q = 4'd8;
		k_q = 9'd256;
		alpha_q = FP_ONE;
		beta_q = FP_ONE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_specials();
		test_shapes();
		test_random();
		drain();
		$display("sent %0d words with %0d computes, checked %0d C entries",
			words_sent, computes_sent, entries_seen);
		$display("covered special values, zero and saturated shapes, and random tiles");
		if (errors == 0 && expected_entries.size() == 0)
			$display("** gemm_tile_alpha_beta_fp64: PASSED **");
		else
			$display("** gemm_tile_alpha_beta_fp64: FAILED **");
		$finish;
	end

endmodule

/* files.f */
rtl/gemm_pkg.sv
rtl/gemm_ram.sv
rtl/gemm_fma.sv
rtl/gemm_tile_alpha_beta_fp64.sv
rtl/gemm_chk.sv
sim/tb.sv
